// ----- sv/ebm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_pkg
// Shared constants, codes and control types of the byte memory with endian
// select.
// ----------------------------------------------------------------------------
package ebm_pkg;

    localparam int MEM_BYTES  = 65536;
    localparam int BANKS      = 4;
    localparam int BANK_DEPTH = MEM_BYTES / BANKS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ADDR_W     = ROW_W + 2;

    localparam int                SIZE_W     = 17;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h10000;

    localparam logic [2:0] MODE_WR_WORD = 3'd5;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    typedef struct packed {
        logic clear;
        logic capture;
        logic access;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

// ----- sv/ebm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_ram
// Generic single-port RAM with one registered read or one write per cycle.
// ----------------------------------------------------------------------------
module ebm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ebm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_ctrl
// Controller: runs the clearing pass after reset, then sequences each
// request through capture, bank access, result load and delivery.
// ----------------------------------------------------------------------------
module ebm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ebm_pkg::t_sts i_sts,
    output ebm_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_LOAD,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_ACCESS;
                        r_in_stall <= 1'b1;
                    end
                end
                S_ACCESS: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_CLEAR;
                    r_in_stall  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.access  = (r_state == S_ACCESS);
        o_cmd.load    = (r_state == S_LOAD);
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/ebm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_datapath
// Datapath: size register, bound check, request registers, four byte banks
// with lane rotation and endian ordering, and the result register.
// ----------------------------------------------------------------------------
module ebm_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ebm_pkg::t_cmd              i_cmd,
    output ebm_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [ebm_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic [2:0]                 i_mode,
    input  logic [31:0]                i_address,
    input  logic                       i_big_endian,
    input  logic [31:0]                i_write_data,
    output logic [31:0]                o_read_data,
    output logic                       o_status
);

    logic [ebm_pkg::SIZE_W-1:0] r_size;
    logic [ebm_pkg::ROW_W-1:0]  r_clr_row;

    logic [ebm_pkg::ADDR_W-1:0] r_addr;
    logic [1:0]                 r_size_code;
    logic                       r_write;
    logic                       r_be;
    logic [31:0]                r_wdata;
    logic                       r_err;
    logic [31:0]                r_read_data;
    logic                       r_status;

    logic [2:0]  w_nbytes;
    logic [32:0] w_end;
    logic [32:0] w_limit;
    logic        w_err;
    logic [1:0]  w_nm1;
    logic [31:0] w_rdata;

    logic [1:0]                w_off  [ebm_pkg::BANKS];
    logic                      w_act  [ebm_pkg::BANKS];
    logic [1:0]                w_sig  [ebm_pkg::BANKS];
    logic [ebm_pkg::ROW_W-1:0] w_row  [ebm_pkg::BANKS];
    logic                      w_en   [ebm_pkg::BANKS];
    logic                      w_we   [ebm_pkg::BANKS];
    logic [ebm_pkg::ROW_W-1:0] w_addr [ebm_pkg::BANKS];
    logic [7:0]                w_wd   [ebm_pkg::BANKS];
    logic [7:0]                w_rd   [ebm_pkg::BANKS];

    always_comb begin
        unique case (i_mode[2:1])
            ebm_pkg::SZ_BYTE: w_nbytes = 3'd1;
            ebm_pkg::SZ_HALF: w_nbytes = 3'd2;
            default:          w_nbytes = 3'd4;
        endcase
        w_end   = {1'b0, i_address} + 33'(w_nbytes);
        w_limit = ({16'b0, r_size} > 33'(ebm_pkg::MEM_BYTES)) ?
                  33'(ebm_pkg::MEM_BYTES) : {16'b0, r_size};
        w_err   = (i_mode > ebm_pkg::MODE_WR_WORD) || (w_end > w_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= ebm_pkg::SIZE_RESET;
            r_clr_row <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + ebm_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr      <= i_address[ebm_pkg::ADDR_W-1:0];
            r_size_code <= i_mode[2:1];
            r_write     <= i_mode[0];
            r_be        <= i_big_endian;
            r_wdata     <= i_write_data;
            r_err       <= w_err;
        end
        if (i_cmd.load) begin
            r_read_data <= w_rdata;
            r_status    <= r_err;
        end
    end

    assign o_sts.clear_last = (r_clr_row == ebm_pkg::ROW_W'(ebm_pkg::BANK_DEPTH - 1));

    always_comb begin
        unique case (r_size_code)
            ebm_pkg::SZ_BYTE: w_nm1 = 2'd0;
            ebm_pkg::SZ_HALF: w_nm1 = 2'd1;
            default:          w_nm1 = 2'd3;
        endcase
    end

    // Bank b holds the byte at offset (b - address) mod 4 of the request;
    // banks below the start lane take the next row.
    always_comb begin
        for (int b = 0; b < ebm_pkg::BANKS; b++) begin
            w_off[b] = 2'(b) - r_addr[1:0];
            w_act[b] = (w_off[b] <= w_nm1);
            w_sig[b] = r_be ? (w_nm1 - w_off[b]) : w_off[b];
            w_row[b] = r_addr[ebm_pkg::ADDR_W-1:2]
                       + ebm_pkg::ROW_W'(2'(b) < r_addr[1:0]);
            if (i_cmd.clear) begin
                w_en[b]   = 1'b1;
                w_we[b]   = 1'b1;
                w_addr[b] = r_clr_row;
                w_wd[b]   = 8'h00;
            end else begin
                w_en[b]   = i_cmd.access && w_act[b] && !r_err;
                w_we[b]   = i_cmd.access && w_act[b] && !r_err && r_write;
                w_addr[b] = w_row[b];
                w_wd[b]   = r_wdata[{w_sig[b], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        w_rdata = '0;
        for (int b = 0; b < ebm_pkg::BANKS; b++) begin
            if (w_act[b]) begin
                w_rdata[{w_sig[b], 3'b000} +: 8] = w_rd[b];
            end
        end
        if (r_err || r_write) begin
            w_rdata = '0;
        end
    end

    for (genvar g = 0; g < ebm_pkg::BANKS; g++) begin : gen_bank
        ebm_ram #(
            .WIDTH (8),
            .DEPTH (ebm_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (w_en[g]),
            .i_we    (w_we[g]),
            .i_addr  (w_addr[g]),
            .i_wdata (w_wd[g]),
            .o_rdata (w_rd[g])
        );
    end

    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

// ----- sv/endian_byte_memory.sv -----
`timescale 1ns / 1ps
// An accepted request passes the access and load states before its result
// is registered as valid. Requests do not overlap: each makes one bank port
// pass (access, registered read, result load, delivery) before the next is
// accepted. Reset: a clearing pass writes zero to all MEM_BYTES / 4 rows,
// with requests stalled; the size register resets to 65536.
// ----------------------------------------------------------------------------
// endian_byte_memory
// Byte-addressed data memory with byte, halfword and word accesses at any
// alignment, per-request endian select and a configurable size bound.
// ----------------------------------------------------------------------------
module endian_byte_memory (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ebm_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_mode,
    input  logic [31:0]                i_address,
    input  logic                       i_big_endian,
    input  logic [31:0]                i_write_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [31:0]                o_read_data,
    output logic                       o_status
);

    ebm_pkg::t_cmd w_cmd;
    ebm_pkg::t_sts w_sts;

    ebm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ebm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_big_endian (i_big_endian),
        .i_write_data (i_write_data),
        .o_read_data  (o_read_data),
        .o_status     (o_status)
    );

endmodule

// ----- sv/ebm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_checker
// Port-level checks of the byte memory: request sequencing, result timing
// and result contents for writes and failed requests.
// ----------------------------------------------------------------------------
module ebm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_mode,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_data,
    input logic        o_status
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_read_data) && $stable(o_status))
        else $error("Stalled result changed.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Request accepted while a result waits.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_read_data == 32'd0)
        else $error("Failed request returned nonzero data.");

    a_bad_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_mode > ebm_pkg::MODE_WR_WORD) |->
            ##3 o_out_valid && o_status)
        else $error("Unused mode did not fail three cycles later.");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_mode[0] |-> ##3 o_out_valid && (o_read_data == 32'd0))
        else $error("Write request returned nonzero data.");

endmodule

bind endian_byte_memory ebm_checker u_ebm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data),
    .o_status    (o_status)
);
